@@ hw/rtl/csp_pkg.sv @@
// ============================================================================
// csp_pkg
// Shared types and constants for the closest segment projection block and
// its multi-cycle multiplier.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

    // Multiplier geometry: operands are taken apart into 32-bit limbs.
    localparam int LIMB_W    = 32;
    localparam int MUL_LIMBS = 3;
    localparam int MUL_W     = LIMB_W * MUL_LIMBS;
    localparam int PROD_W    = 2 * MUL_W;

    // Quotient bits produced by the restoring divider, one per cycle.
    localparam int DIV_STEPS = 32;

    // Number of coordinate axes.
    localparam int AXES = 3;

    // Command codes.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NONE = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DIST_TOL  = 1'b0;
    localparam logic CFG_PARAM_TOL = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_DM,
        ST_DIV,
        ST_BEST,
        ST_NEXT,
        ST_RESP
    } t_state;

    // Operations issued to the shared multiplier.
    typedef enum logic [3:0] {
        OP_DT2,
        OP_DOT,
        OP_LEN,
        OP_D2L,
        OP_CLIPA,
        OP_CLIPB,
        OP_COIN,
        OP_DIVM,
        OP_DIST
    } t_op;

    // One stored segment; element 0 of each coordinate triple is x.
    typedef struct packed {
        logic [2:0][31:0] s;
        logic [2:0][31:0] e;
        logic [15:0]      si;
        logic [15:0]      ei;
        logic [15:0]      ch;
    } t_entry;

    // Magnitude of a 33-bit signed difference of two 32-bit values.
    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return m[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/csp_mul.sv @@
// ============================================================================
// csp_mul
// Multi-cycle unsigned multiplier: one 32x32 limb product per cycle,
// accumulated into a wide register in the next cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module csp_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [csp_pkg::MUL_W-1:0]   i_a,
    input  logic [csp_pkg::MUL_W-1:0]   i_b,
    output logic                        o_done,
    output logic [csp_pkg::PROD_W-1:0]  o_prod
);
    import csp_pkg::*;

    logic [MUL_W-1:0]    r_a;
    logic [MUL_W-1:0]    r_b;
    logic [1:0]          r_i;
    logic [1:0]          r_j;
    logic                r_run;
    logic [2*LIMB_W-1:0] r_pp;
    logic                r_ppv;
    logic                r_pplast;
    logic [2:0]          r_sh;
    logic [PROD_W-1:0]   r_acc;
    logic                r_done;

    logic                w_last_i;
    logic                w_last_j;
    logic [LIMB_W-1:0]   w_la;
    logic [LIMB_W-1:0]   w_lb;
    logic [PROD_W-1:0]   w_pp_sh;

    // Limb selection and placement of the partial product.
    assign w_last_i = (r_i == 2'(MUL_LIMBS - 1));
    assign w_last_j = (r_j == 2'(MUL_LIMBS - 1));
    assign w_la     = r_a[LIMB_W*r_i +: LIMB_W];
    assign w_lb     = r_b[LIMB_W*r_j +: LIMB_W];
    assign w_pp_sh  = PROD_W'(r_pp) << (LIMB_W * r_sh);

    // Limb walk control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_ppv    <= 1'b0;
            r_pplast <= 1'b0;
            r_done   <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
        end else begin
            r_ppv    <= r_run;
            r_pplast <= r_run && w_last_i && w_last_j;
            r_done   <= r_ppv && r_pplast;
            if (i_start) begin
                r_run <= 1'b1;
                r_i   <= '0;
                r_j   <= '0;
            end else if (r_run) begin
                if (w_last_j) begin
                    r_j <= '0;
                    if (w_last_i) begin
                        r_run <= 1'b0;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end else begin
                    r_j <= r_j + 2'd1;
                end
            end
        end
    end

    // Operand capture, limb product and accumulation.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_pp <= w_la * w_lb;
        r_sh <= 3'(r_i) + 3'(r_j);
        if (i_start) begin
            r_acc <= '0;
        end else if (r_ppv) begin
            r_acc <= r_acc + w_pp_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ hw/rtl/closest_segment_projection.sv @@
// ============================================================================
// closest_segment_projection
// Segment table with nearest-projection search of a query point.
// ============================================================================
// Clear, append and the unused command give their result word on the cycle
// after the command is taken; busy stays low. A query keeps busy high while
// it walks the table one segment at a time through a single shared
// multiplier (nine 32x32 limb products per operation) and a
// one-bit-per-cycle divider. A segment of another chain is skipped without
// a multiply; a segment clipped to an endpoint needs no division; an
// interior projection runs three 32-step divisions, one per axis. Each
// result word is shown for exactly one cycle with o_valid and must be taken
// then: there is no back-pressure on the result side. Configuration writes
// are always accepted and should be made while the block is idle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module closest_segment_projection #(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic [15:0]        i_start_index,
    input  logic [15:0]        i_end_index,
    input  logic [15:0]        i_chain_id,
    input  logic signed [16:0] i_required_chain,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_proj_x,
    output logic signed [31:0] o_proj_y,
    output logic signed [31:0] o_proj_z,
    output logic [7:0]         o_edge_index,
    output logic [15:0]        o_edge_chain,
    output logic               o_endpoint_found,
    output logic [15:0]        o_endpoint_index
);
    import csp_pkg::*;

    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int DCW = $clog2(DIV_STEPS);

    // Control state.
    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [1:0]          r_axis, n_axis;
    logic                r_go, n_go;
    logic                r_valid, n_valid;
    logic [CW-1:0]       r_count;
    logic [30:0]         r_dist_tol;
    logic [15:0]         r_param_tol;

    // Segment table and the entry under work.
    t_entry              r_mem [MAX_SEGMENTS];
    t_entry              r_rd;
    t_entry              w_new;

    // Query and per-segment datapath registers.
    logic [CW-1:0]       r_k;
    logic signed [31:0]  r_p [AXES];
    logic [16:0]         r_req;
    logic signed [32:0]  r_ev [AXES];
    logic signed [32:0]  r_cv [AXES];
    logic [65:0]         r_pos;
    logic [65:0]         r_neg;
    logic [65:0]         r_len2;
    logic [65:0]         r_dm;
    logic [61:0]         r_dt2;
    logic [127:0]        r_d2l;
    logic signed [31:0]  r_q [AXES];
    logic                r_at_end;
    logic                r_found;
    logic [15:0]         r_eidx;
    logic [97:0]         r_rem;
    logic [96:0]         r_dsh;
    logic [31:0]         r_quo;
    logic [DCW-1:0]      r_dcnt;
    logic [65:0]         r_dist;
    logic                r_any;
    logic [65:0]         r_best;

    // Result word registers.
    logic [1:0]          r_o_status;
    logic [2:0][31:0]    r_o_proj;
    logic [7:0]          r_o_edge;
    logic [15:0]         r_o_chain;
    logic                r_o_found;
    logic [15:0]         r_o_eidx;

    // Combinational helpers.
    logic                w_accept;
    logic                w_room;
    logic                w_mul_done;
    logic [PROD_W-1:0]   w_prod;
    logic [MUL_W-1:0]    w_ma;
    logic [MUL_W-1:0]    w_mb;
    logic                w_last_axis;
    logic                w_skip;
    logic                w_k_last;
    logic                w_isneg;
    logic [81:0]         w_dm_sh;
    logic                w_clip_start;
    logic                w_clip_end;
    logic                w_coin_ok;
    logic [65:0]         w_df;
    logic                w_div_ge;
    logic                w_div_last;
    logic [31:0]         w_quo_n;
    logic [31:0]         w_qi;
    logic signed [32:0]  w_qp;
    logic                w_better;

    // Handshake and simple decisions.
    assign busy         = (r_state != ST_IDLE);
    assign w_accept     = start && !busy;
    assign w_room       = (r_count < CW'(MAX_SEGMENTS));
    assign w_last_axis  = (r_axis == 2'(AXES - 1));
    assign w_skip       = !r_req[16] && (r_rd.ch != r_req[15:0]);
    assign w_k_last     = ((r_k + CW'(1)) >= r_count);
    assign w_isneg      = (r_pos < r_neg);
    assign w_dm_sh      = {r_dm, 16'b0};
    assign w_clip_start = (w_dm_sh <= w_prod[81:0]);
    assign w_clip_end   = (w_dm_sh >= w_prod[81:0]);
    assign w_coin_ok    = (w_prod[131:0] <= {4'b0, r_d2l});
    assign w_df         = (r_len2 >= r_dm) ? (r_len2 - r_dm) : (r_dm - r_len2);
    assign w_div_ge     = ({1'b0, r_dsh} <= r_rem);
    assign w_div_last   = (r_dcnt == DCW'(DIV_STEPS - 1));
    assign w_quo_n      = {r_quo[30:0], w_div_ge};
    assign w_qi         = r_ev[r_axis][32] ? (r_rd.s[r_axis] - w_quo_n)
                                           : (r_rd.s[r_axis] + w_quo_n);
    assign w_qp         = 33'(r_q[r_axis]) - 33'(r_p[r_axis]);
    assign w_better     = !r_any || (r_dist < r_best);

    // Word written on an append.
    assign w_new.s  = {i_az, i_ay, i_ax};
    assign w_new.e  = {i_bz, i_by, i_bx};
    assign w_new.si = i_start_index;
    assign w_new.ei = i_end_index;
    assign w_new.ch = i_chain_id;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_op)
            OP_DT2: begin
                w_ma = MUL_W'(r_dist_tol);
                w_mb = MUL_W'(r_dist_tol);
            end
            OP_DOT: begin
                w_ma = MUL_W'(mag33(r_cv[r_axis]));
                w_mb = MUL_W'(mag33(r_ev[r_axis]));
            end
            OP_LEN: begin
                w_ma = MUL_W'(mag33(r_ev[r_axis]));
                w_mb = MUL_W'(mag33(r_ev[r_axis]));
            end
            OP_D2L: begin
                w_ma = MUL_W'(r_dt2);
                w_mb = MUL_W'(r_len2);
            end
            OP_CLIPA: begin
                w_ma = MUL_W'(r_param_tol);
                w_mb = MUL_W'(r_len2);
            end
            OP_CLIPB: begin
                w_ma = MUL_W'(17'h10000 - 17'(r_param_tol));
                w_mb = MUL_W'(r_len2);
            end
            OP_COIN: begin
                w_ma = MUL_W'(r_at_end ? w_df : r_dm);
                w_mb = MUL_W'(r_at_end ? w_df : r_dm);
            end
            OP_DIVM: begin
                w_ma = MUL_W'(r_dm);
                w_mb = MUL_W'(mag33(r_ev[r_axis]));
            end
            OP_DIST: begin
                w_ma = MUL_W'(mag33(w_qp));
                w_mb = MUL_W'(mag33(w_qp));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    csp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_axis  = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_cmd == CMD_QUERY)) begin
                    if (r_count == '0) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_MUL;
                        n_op    = OP_DT2;
                    end
                end
            end
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: begin
                if (w_skip) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_MUL;
                    n_op    = OP_DOT;
                    n_axis  = '0;
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    unique case (r_op)
                        OP_DT2: n_state = ST_READ;
                        OP_DOT: begin
                            if (w_last_axis) begin
                                n_op   = OP_LEN;
                                n_axis = '0;
                            end else begin
                                n_axis = r_axis + 2'd1;
                            end
                        end
                        OP_LEN: begin
                            if (w_last_axis) begin
                                n_state = ST_DM;
                            end else begin
                                n_axis = r_axis + 2'd1;
                            end
                        end
                        OP_CLIPA: n_op = w_clip_start ? OP_D2L : OP_CLIPB;
                        OP_CLIPB: begin
                            if (w_clip_end) begin
                                n_op = OP_D2L;
                            end else begin
                                n_op   = OP_DIVM;
                                n_axis = '0;
                            end
                        end
                        OP_D2L: n_op = OP_COIN;
                        OP_COIN: begin
                            n_op   = OP_DIST;
                            n_axis = '0;
                        end
                        OP_DIVM: n_state = ST_DIV;
                        OP_DIST: begin
                            if (w_last_axis) begin
                                n_state = ST_BEST;
                            end else begin
                                n_axis = r_axis + 2'd1;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DM: begin
                n_state = ST_MUL;
                n_op    = w_isneg ? OP_D2L : OP_CLIPA;
            end
            ST_DIV: begin
                if (w_div_last) begin
                    n_state = ST_MUL;
                    if (w_last_axis) begin
                        n_op   = OP_DIST;
                        n_axis = '0;
                    end else begin
                        n_op   = OP_DIVM;
                        n_axis = r_axis + 2'd1;
                    end
                end
            end
            ST_BEST: n_state = ST_NEXT;
            ST_NEXT: n_state = w_k_last ? ST_RESP : ST_READ;
            ST_RESP: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier launch and result strobe.
    always_comb begin
        n_go    = (n_state == ST_MUL) && ((r_state != ST_MUL) || w_mul_done);
        n_valid = (r_state == ST_RESP) || (w_accept && (i_cmd != CMD_QUERY));
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_DT2;
            r_axis      <= '0;
            r_go        <= 1'b0;
            r_valid     <= 1'b0;
            r_count     <= '0;
            r_dist_tol  <= 31'd66;
            r_param_tol <= 16'd1;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_axis  <= n_axis;
            r_go    <= n_go;
            r_valid <= n_valid;
            if (w_accept && (i_cmd == CMD_CLEAR)) begin
                r_count <= '0;
            end else if (w_accept && (i_cmd == CMD_APPEND) && w_room) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DIST_TOL:  r_dist_tol  <= i_cfg_data[30:0];
                    CFG_PARAM_TOL: r_param_tol <= i_cfg_data[15:0];
                endcase
            end
        end
    end

    // Segment table: one write port for appends, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_cmd == CMD_APPEND) && w_room) begin
            r_mem[r_count[AW-1:0]] <= w_new;
        end
        if (r_state == ST_READ) begin
            r_rd <= r_mem[r_k[AW-1:0]];
        end
    end

    // Datapath and result word.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_o_status <= STAT_OK;
                    r_o_proj   <= '0;
                    r_o_edge   <= '0;
                    r_o_chain  <= '0;
                    r_o_found  <= 1'b0;
                    r_o_eidx   <= '0;
                    unique case (i_cmd)
                        CMD_CLEAR: ;
                        CMD_APPEND: begin
                            if (w_room) begin
                                r_o_edge <= 8'(r_count);
                            end else begin
                                r_o_status <= STAT_FULL;
                            end
                        end
                        CMD_QUERY: begin
                            r_o_status <= STAT_NONE;
                            r_p[0]     <= i_ax;
                            r_p[1]     <= i_ay;
                            r_p[2]     <= i_az;
                            r_req      <= i_required_chain;
                            r_k        <= '0;
                            r_any      <= 1'b0;
                        end
                        CMD_NOP: ;
                    endcase
                end
            end
            ST_LOAD: begin
                for (int i = 0; i < AXES; i++) begin
                    r_ev[i] <= 33'($signed(r_rd.e[i])) - 33'($signed(r_rd.s[i]));
                    r_cv[i] <= 33'(r_p[i]) - 33'($signed(r_rd.s[i]));
                end
                r_pos  <= '0;
                r_neg  <= '0;
                r_len2 <= '0;
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    unique case (r_op)
                        OP_DT2: r_dt2 <= w_prod[61:0];
                        OP_DOT: begin
                            if (r_cv[r_axis][32] != r_ev[r_axis][32]) begin
                                r_neg <= r_neg + w_prod[65:0];
                            end else begin
                                r_pos <= r_pos + w_prod[65:0];
                            end
                        end
                        OP_LEN: r_len2 <= r_len2 + w_prod[65:0];
                        OP_CLIPA: begin
                            if (w_clip_start) begin
                                for (int i = 0; i < AXES; i++) begin
                                    r_q[i] <= $signed(r_rd.s[i]);
                                end
                                r_at_end <= 1'b0;
                            end
                        end
                        OP_CLIPB: begin
                            if (w_clip_end) begin
                                for (int i = 0; i < AXES; i++) begin
                                    r_q[i] <= $signed(r_rd.e[i]);
                                end
                                r_at_end <= 1'b1;
                            end else begin
                                r_found <= 1'b0;
                                r_eidx  <= '0;
                            end
                        end
                        OP_D2L: r_d2l <= w_prod[127:0];
                        OP_COIN: begin
                            r_found <= w_coin_ok;
                            if (!w_coin_ok) begin
                                r_eidx <= '0;
                            end else if (r_at_end) begin
                                r_eidx <= r_rd.ei;
                            end else begin
                                r_eidx <= r_rd.si;
                            end
                        end
                        OP_DIVM: begin
                            r_rem  <= w_prod[97:0];
                            r_dsh  <= {r_len2, 31'b0};
                            r_quo  <= '0;
                            r_dcnt <= '0;
                        end
                        OP_DIST: begin
                            if (r_axis == '0) begin
                                r_dist <= w_prod[65:0];
                            end else begin
                                r_dist <= r_dist + w_prod[65:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DM: begin
                r_dm <= w_isneg ? (r_neg - r_pos) : (r_pos - r_neg);
                if (w_isneg) begin
                    for (int i = 0; i < AXES; i++) begin
                        r_q[i] <= $signed(r_rd.s[i]);
                    end
                    r_at_end <= 1'b0;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit a cycle.
                if (w_div_ge) begin
                    r_rem <= r_rem - {1'b0, r_dsh};
                end
                r_dsh  <= r_dsh >> 1;
                r_quo  <= w_quo_n;
                r_dcnt <= r_dcnt + DCW'(1);
                if (w_div_last) begin
                    r_q[r_axis] <= $signed(w_qi);
                end
            end
            ST_BEST: begin
                // Strictly nearer wins, so the lowest index keeps a tie.
                if (w_better) begin
                    r_any      <= 1'b1;
                    r_best     <= r_dist;
                    r_o_status <= STAT_OK;
                    for (int i = 0; i < AXES; i++) begin
                        r_o_proj[i] <= r_q[i];
                    end
                    r_o_edge   <= 8'(r_k);
                    r_o_chain  <= r_rd.ch;
                    r_o_found  <= r_found;
                    r_o_eidx   <= r_eidx;
                end
            end
            ST_NEXT: r_k <= r_k + CW'(1);
            ST_READ: ;
            ST_RESP: ;
            default: ;
        endcase
    end

    // Ports.
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_valid;
    assign o_status         = r_o_status;
    assign o_proj_x         = $signed(r_o_proj[0]);
    assign o_proj_y         = $signed(r_o_proj[1]);
    assign o_proj_z         = $signed(r_o_proj[2]);
    assign o_edge_index     = r_o_edge;
    assign o_edge_chain     = r_o_chain;
    assign o_endpoint_found = r_o_found;
    assign o_endpoint_index = r_o_eidx;

    // Checks on the sequencer.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    a_go_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> (r_state == ST_MUL))
        else $error("multiplier launched outside a multiply step");

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == ST_MUL) && !r_go)
        else $error("multiplier finished while not awaited");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_k < r_count))
        else $error("table read beyond stored segments");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_QUERY)) |=> busy)
        else $error("query taken without going busy");

endmodule

`default_nettype wire

@@ sim/csp_checker.sv @@
// ============================================================================
// csp_checker
// Watches the command, configuration and result channels of the closest
// segment projection block, predicts every result word and compares it.
// ============================================================================
// A private copy of the segment table and both tolerances is kept. Every
// accepted command word produces one expected result word, which is queued.
// Each strobed result word is compared field by field with the oldest entry.
// All squared quantities are worked out exactly in 192-bit arithmetic.
// ============================================================================
`timescale 1ns / 1ps

module csp_checker
    import csp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic [15:0]        i_start_index,
    input  logic [15:0]        i_end_index,
    input  logic [15:0]        i_chain_id,
    input  logic signed [16:0] i_required_chain,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic [1:0]         i_status,
    input  logic signed [31:0] i_proj_x,
    input  logic signed [31:0] i_proj_y,
    input  logic signed [31:0] i_proj_z,
    input  logic [7:0]         i_edge_index,
    input  logic [15:0]        i_edge_chain,
    input  logic               i_endpoint_found,
    input  logic [15:0]        i_endpoint_index,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef logic [191:0] t_wide;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [7:0]  edge_idx;
        logic [15:0] chain;
        logic        found;
        logic [15:0] eidx;
    } t_result;

    // Private copy of the table and of the tolerances.
    longint      tbl_s [256][3];
    longint      tbl_e [256][3];
    logic [15:0] tbl_si [256];
    logic [15:0] tbl_ei [256];
    logic [15:0] tbl_ch [256];
    int          tbl_count;
    logic [30:0] dist_tol;
    logic [15:0] param_tol;

    t_result     expected_words [$];

    function automatic t_wide wmag(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        return t_wide'(m);
    endfunction

    // Projects point p onto entry k; returns the squared distance to it.
    function automatic t_wide project_onto(input int k, input longint p [3],
                                           output longint q [3],
                                           output logic found,
                                           output logic [15:0] eidx);
        longint ev [3];
        longint cv [3];
        t_wide  pos, neg, len2, dm, d2l, df, sq_dist;
        logic   isneg;
        pos = '0; neg = '0; len2 = '0; sq_dist = '0;
        for (int i = 0; i < 3; i++) begin
            ev[i] = tbl_e[k][i] - tbl_s[k][i];
            cv[i] = p[i] - tbl_s[k][i];
            if ((cv[i] < 0) != (ev[i] < 0)) begin
                neg += wmag(cv[i]) * wmag(ev[i]);
            end else begin
                pos += wmag(cv[i]) * wmag(ev[i]);
            end
            len2 += wmag(ev[i]) * wmag(ev[i]);
        end
        isneg = pos < neg;
        dm    = isneg ? neg - pos : pos - neg;
        d2l   = t_wide'(dist_tol) * t_wide'(dist_tol) * len2;
        found = 1'b0;
        eidx  = '0;
        if (isneg || (dm << 16) <= t_wide'(param_tol) * len2) begin
            // Clipped to the start; a zero-length segment always lands here.
            for (int i = 0; i < 3; i++) q[i] = tbl_s[k][i];
            if (dm * dm <= d2l) begin
                found = 1'b1;
                eidx  = tbl_si[k];
            end
        end else if ((dm << 16) >= t_wide'(17'd65536 - param_tol) * len2) begin
            df = (len2 >= dm) ? len2 - dm : dm - len2;
            for (int i = 0; i < 3; i++) q[i] = tbl_e[k][i];
            if (df * df <= d2l) begin
                found = 1'b1;
                eidx  = tbl_ei[k];
            end
        end else begin
            // Interior point, each offset truncated towards zero.
            for (int i = 0; i < 3; i++) begin
                t_wide quo;
                quo = (dm * wmag(ev[i])) / len2;
                q[i] = (ev[i] < 0) ? tbl_s[k][i] - longint'(quo[63:0])
                                   : tbl_s[k][i] + longint'(quo[63:0]);
            end
        end
        for (int i = 0; i < 3; i++) sq_dist += wmag(q[i] - p[i]) * wmag(q[i] - p[i]);
        return sq_dist;
    endfunction

    // Applies one command word to the private state and returns its result.
    function automatic t_result apply_command();
        t_result r;
        longint  p [3];
        longint  q [3];
        logic    found, any;
        logic [15:0] eidx;
        t_wide   d, best;
        r = '{default: '0};
        case (i_cmd)
            CMD_CLEAR: begin
                tbl_count = 0;
            end
            CMD_APPEND: begin
                if (tbl_count >= 256) begin
                    r.status = STAT_FULL;
                end else begin
                    tbl_s[tbl_count] = '{i_ax, i_ay, i_az};
                    tbl_e[tbl_count] = '{i_bx, i_by, i_bz};
                    tbl_si[tbl_count] = i_start_index;
                    tbl_ei[tbl_count] = i_end_index;
                    tbl_ch[tbl_count] = i_chain_id;
                    r.edge_idx = 8'(tbl_count);
                    tbl_count++;
                end
            end
            CMD_QUERY: begin
                p = '{i_ax, i_ay, i_az};
                r.status = STAT_NONE;
                any  = 1'b0;
                best = '0;
                for (int k = 0; k < tbl_count; k++) begin
                    if (!i_required_chain[16] && tbl_ch[k] != i_required_chain[15:0])
                        continue;
                    d = project_onto(k, p, q, found, eidx);
                    if (!any || d < best) begin
                        any        = 1'b1;
                        best       = d;
                        r.status   = STAT_OK;
                        r.px       = q[0][31:0];
                        r.py       = q[1][31:0];
                        r.pz       = q[2][31:0];
                        r.edge_idx = 8'(k);
                        r.chain    = tbl_ch[k];
                        r.found    = found;
                        r.eidx     = eidx;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // Result words are checked before the command of the same edge is taken.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            tbl_count    = 0;
            dist_tol     = 31'd66;
            param_tol    = 16'd1;
            o_fail_count = 0;
            expected_words.delete();
        end else begin
            if (i_valid) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, status %0d", $time, i_status);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    compare_field("status", want.status, i_status);
                    compare_field("proj_x", want.px, $unsigned(i_proj_x));
                    compare_field("proj_y", want.py, $unsigned(i_proj_y));
                    compare_field("proj_z", want.pz, $unsigned(i_proj_z));
                    compare_field("edge_index", want.edge_idx, i_edge_index);
                    compare_field("edge_chain", want.chain, i_edge_chain);
                    compare_field("endpoint_found", want.found, i_endpoint_found);
                    compare_field("endpoint_index", want.eidx, i_endpoint_index);
                end
            end
            if (start && !busy) expected_words.push_back(apply_command());
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DIST_TOL) dist_tol = i_cfg_data[30:0];
                else param_tol = i_cfg_data[15:0];
            end
        end
        o_pending = expected_words.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

@@ sim/tb.sv @@
// ============================================================================
// tb
// Stimulus and verdict for the closest segment projection block.
// ============================================================================
// A short directed part covers the empty table, the unused command, field
// extremes, zero-length segments, endpoint coincidence and chain filtering.
// Random phases then set the tolerances, build small tables and query points
// near endpoints, around the origin and anywhere; the last phases insert no
// random idle gaps. The checker beside the block predicts and compares every
// result word.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import csp_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_cmd;
    logic signed [31:0] i_ax, i_ay, i_az, i_bx, i_by, i_bz;
    logic [15:0]        i_start_index, i_end_index, i_chain_id;
    logic signed [16:0] i_required_chain;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_proj_x, o_proj_y, o_proj_z;
    logic [7:0]         o_edge_index;
    logic [15:0]        o_edge_chain;
    logic               o_endpoint_found;
    logic [15:0]        o_endpoint_index;
    int                 fail_count;
    int                 pending;

    logic               gaps_on;
    logic signed [31:0] last_s [3];
    logic signed [31:0] last_e [3];
    logic [15:0]        chain_a, chain_b;

    closest_segment_projection DUT (.*);

    csp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_ax(i_ax), .i_ay(i_ay), .i_az(i_az),
        .i_bx(i_bx), .i_by(i_by), .i_bz(i_bz),
        .i_start_index(i_start_index), .i_end_index(i_end_index),
        .i_chain_id(i_chain_id), .i_required_chain(i_required_chain),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid), .i_status(o_status),
        .i_proj_x(o_proj_x), .i_proj_y(o_proj_y), .i_proj_z(o_proj_z),
        .i_edge_index(o_edge_index), .i_edge_chain(o_edge_chain),
        .i_endpoint_found(o_endpoint_found), .i_endpoint_index(o_endpoint_index),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Drives one command word and returns on the edge that takes it.
    task automatic issue(input logic [1:0] cmd,
                         input logic signed [31:0] ax, ay, az, bx, by, bz,
                         input logic [15:0] si, ei, ch,
                         input logic signed [16:0] rc);
        logic taken;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_ax <= ax; i_ay <= ay; i_az <= az;
        i_bx <= bx; i_by <= by; i_bz <= bz;
        i_start_index <= si; i_end_index <= ei; i_chain_id <= ch;
        i_required_chain <= rc;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic append(input logic signed [31:0] ax, ay, az, bx, by, bz,
                          input logic [15:0] ch);
        last_s = '{ax, ay, az};
        last_e = '{bx, by, bz};
        issue(CMD_APPEND, ax, ay, az, bx, by, bz, 16'($urandom), 16'($urandom), ch,
              17'($urandom));
    endtask

    task automatic query(input logic signed [31:0] px, py, pz,
                         input logic signed [16:0] rc);
        issue(CMD_QUERY, px, py, pz, 32'($urandom), 32'($urandom), 32'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), rc);
    endtask

    task automatic simple(input logic [1:0] cmd);
        issue(cmd, 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
              32'($urandom), 32'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 17'($urandom));
    endtask

    // Waits until every word taken so far has been answered.
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [31:0] data);
        logic taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
    endtask

    // Coordinates: mostly within 10 << 16 of the origin on each axis, sometimes anywhere.
    function automatic logic signed [31:0] coord();
        if ($urandom_range(0, 4) == 0) return 32'($urandom);
        return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endfunction

    function automatic logic signed [31:0] jitter(input logic signed [31:0] v);
        return v + 32'($signed($urandom_range(0, 200)) - 100);
    endfunction

    function automatic logic signed [16:0] pick_chain();
        case ($urandom_range(0, 4))
            0: return -17'sd1;
            1: return 17'($urandom) | 17'h10000;
            2: return {1'b0, chain_a};
            3: return {1'b0, chain_b};
            default: return {1'b0, 16'($urandom)};
        endcase
    endfunction

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int n_seg;
        int n_q;
        int pick;
        logic signed [31:0] mid [3];
        i_rst_n = 1'b0; start = 1'b0; i_cmd = CMD_NOP;
        i_ax = '0; i_ay = '0; i_az = '0; i_bx = '0; i_by = '0; i_bz = '0;
        i_start_index = '0; i_end_index = '0; i_chain_id = '0;
        i_required_chain = '0; i_cfg_valid = 1'b0; i_cfg_index = CFG_DIST_TOL;
        i_cfg_data = '0; gaps_on = 1'b0; chain_a = 16'd5; chain_b = 16'hFFFF;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset tolerances.
        query(32'sd0, 32'sd0, 32'sd0, -17'sd1);
        simple(CMD_NOP);
        issue(CMD_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              16'h0000, 16'hFFFF, 16'hFFFF, -17'sd1);
        issue(CMD_APPEND, 32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0,
              16'hFFFF, 16'h0000, 16'h0000, 17'h0FFFF);
        issue(CMD_APPEND, 32'sd0, 32'sd0, 32'sd0, 32'sd655360, 32'sd0, 32'sd0,
              16'h1234, 16'h4321, 16'd5, 17'h0);
        query(32'sd40, 32'sd65536, 32'sd0, 17'sd5);
        query(32'sd655300, 32'sd65536, 32'sd0, 17'sd5);
        query(32'sd327680, 32'sd65536, -32'sd65536, 17'sd5);
        query(-32'sd300000, 32'sd0, 32'sd0, 17'sd5);
        query(32'sd65536, 32'sd10, 32'sd0, 17'h00000);
        query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -17'sd1);
        query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 17'h10000);
        query(32'sd0, 32'sd0, 32'sd0, 17'sd77);
        query(32'sd0, 32'sd0, 32'sd0, 17'h0FFFF);
        simple(CMD_CLEAR);
        query(32'sd0, 32'sd0, 32'sd0, -17'sd1);
        drain();

        // Random phases, each under its own tolerances.
        gaps_on = 1'b1;
        for (int ph = 0; ph < 14; ph++) begin
            if (ph == 11) gaps_on = 1'b0;
            case (ph % 4)
                0: write_cfg(CFG_DIST_TOL, 32'd0);
                1: write_cfg(CFG_DIST_TOL, 32'h7FFF_FFFF);
                2: write_cfg(CFG_DIST_TOL, 32'd66);
                default: write_cfg(CFG_DIST_TOL, $urandom_range(0, 1 << 18));
            endcase
            case (ph % 5)
                0: write_cfg(CFG_PARAM_TOL, 32'd0);
                1: write_cfg(CFG_PARAM_TOL, 32'd65535);
                2: write_cfg(CFG_PARAM_TOL, 32'd32768);
                3: write_cfg(CFG_PARAM_TOL, 32'd1);
                default: write_cfg(CFG_PARAM_TOL, $urandom_range(0, 65535));
            endcase
            chain_a = 16'($urandom);
            chain_b = 16'($urandom_range(0, 3));
            simple(CMD_CLEAR);
            n_seg = $urandom_range(1, 5);
            for (int s = 0; s < n_seg; s++) begin
                mid = '{coord(), coord(), coord()};
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    append(mid[0], mid[1], mid[2], mid[0], mid[1], mid[2], chain_a);
                end else begin
                    append(mid[0], mid[1], mid[2], coord(), coord(), coord(),
                           (pick < 6) ? chain_a : chain_b);
                end
            end
            n_q = $urandom_range(2, 4);
            for (int j = 0; j < n_q; j++) begin
                case ($urandom_range(0, 5))
                    0: query(jitter(last_s[0]), jitter(last_s[1]), jitter(last_s[2]),
                             pick_chain());
                    1: query(jitter(last_e[0]), jitter(last_e[1]), jitter(last_e[2]),
                             pick_chain());
                    2: query(32'($urandom), 32'($urandom), 32'($urandom), pick_chain());
                    3: simple(CMD_NOP);
                    default: query(coord(), coord(), coord(), pick_chain());
                endcase
            end
            drain();
        end
        start <= 1'b0;

        // Wait for the last word, with a bound of its own.
        for (int w = 0; w < 200000 && pending != 0; w++) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
